>>> rtl/core/efd_pkg.sv
// Shared types and constants for the escaped frame receive deframer.
package efd_pkg;

  localparam int unsigned MAX_FRAME_LEN = 7;
  localparam int unsigned MIN_FRAME_LEN = 3;
  localparam logic [7:0] ESC_BYTE = 8'h2B;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_CHECKSUM = 2'd1,
    ERR_STATUS   = 2'd2
  } err_code_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic [2:0] length;
    logic       is_esc;
  } rx_item_t;

  typedef struct packed {
    err_code_t   error_code;
    logic [7:0]  device_status;
    logic [31:0] data_value;
    logic        bad_escape;
  } result_t;

endpackage

>>> rtl/core/efd_front.sv
// Front end that classifies each received byte before it is queued.
module efd_front import efd_pkg::*; (
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  input  logic [2:0] frame_length,
  output rx_item_t   item
);

  always_comb begin
    item.data   = rx_byte;
    item.start  = frame_start;
    item.is_esc = (rx_byte == ESC_BYTE);
    if (frame_length < 3'(MIN_FRAME_LEN)) begin
      item.length = 3'(MIN_FRAME_LEN);
    end else if (frame_length > 3'(MAX_FRAME_LEN)) begin
      item.length = 3'(MAX_FRAME_LEN);
    end else begin
      item.length = frame_length;
    end
  end

endmodule

>>> rtl/core/efd_queue.sv
// Short queue of classified bytes between the front and back ends.
module efd_queue import efd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  input  rx_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output rx_item_t pop_item
);

  rx_item_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       count;
  logic                    do_push;
  logic                    do_pop;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/efd_back.sv
// Back end that tracks frame state, collapses escapes and builds results.
module efd_back import efd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  rx_item_t item,
  output logic     pop,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  logic        in_frame, in_frame_next;
  logic [2:0]  count, count_next;
  logic [2:0]  exp_len, exp_len_next;
  logic        esc_pend, esc_pend_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  status, status_next;
  logic [31:0] payload, payload_next;
  logic        esc_err, esc_err_next;
  logic        done;
  result_t     done_result;
  logic        take;
  logic        lone;
  logic        last;
  logic [7:0]  want;

  assign pop  = item_valid && (!done || !result_valid || !result_stall);
  assign want = 8'h00 - sum;
  assign last = ({1'b0, count} + 4'd1) >= {1'b0, exp_len};

  always_comb begin
    in_frame_next = in_frame;
    count_next    = count;
    exp_len_next  = exp_len;
    esc_pend_next = esc_pend;
    sum_next      = sum;
    status_next   = status;
    payload_next  = payload;
    esc_err_next  = esc_err;
    done          = 1'b0;
    take          = 1'b0;
    lone          = 1'b0;
    done_result.error_code    = ERR_OK;
    done_result.device_status = status;
    done_result.data_value    = payload;
    done_result.bad_escape    = esc_err;
    if (item.start) begin
      in_frame_next = 1'b1;
      count_next    = 3'd1;
      exp_len_next  = item.length;
      esc_pend_next = 1'b0;
      sum_next      = '0;
      status_next   = '0;
      payload_next  = '0;
      esc_err_next  = 1'b0;
    end else if (in_frame) begin
      take = 1'b1;
      if (esc_pend) begin
        esc_pend_next = 1'b0;
        if (item.is_esc) begin
          take = 1'b0;
        end else begin
          esc_err_next = 1'b1;
        end
      end else if (item.is_esc) begin
        lone = 1'b1;
      end
      if (take) begin
        if (last) begin
          done = 1'b1;
          if (item.data != want) begin
            done_result.error_code = ERR_CHECKSUM;
          end else if (status != 8'h00) begin
            done_result.error_code = ERR_STATUS;
          end
          done_result.bad_escape = esc_err_next;
          in_frame_next = 1'b0;
          count_next    = '0;
          exp_len_next  = '0;
          esc_pend_next = 1'b0;
          sum_next      = '0;
          status_next   = '0;
          payload_next  = '0;
          esc_err_next  = 1'b0;
        end else begin
          sum_next = sum + item.data;
          unique case (count)
            3'd1:    status_next = item.data;
            3'd2:    payload_next[7:0]   = item.data;
            3'd3:    payload_next[15:8]  = item.data;
            3'd4:    payload_next[23:16] = item.data;
            3'd5:    payload_next[31:24] = item.data;
            default: payload_next = payload;
          endcase
          count_next    = count + 3'd1;
          esc_pend_next = lone;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      count        <= '0;
      exp_len      <= '0;
      esc_pend     <= 1'b0;
      sum          <= '0;
      status       <= '0;
      payload      <= '0;
      esc_err      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        in_frame <= in_frame_next;
        count    <= count_next;
        exp_len  <= exp_len_next;
        esc_pend <= esc_pend_next;
        sum      <= sum_next;
        status   <= status_next;
        payload  <= payload_next;
        esc_err  <= esc_err_next;
      end
      if (pop && done) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && done) begin
      result <= done_result;
    end
  end

endmodule

>>> rtl/core/escaped_frame_receive_deframer_core.sv
// Top level of the escaped frame receive deframer.
// A byte in the queue is popped by the back end when it reaches the head, unless a finished
// frame waits on a stalled result; a frame's last byte loads the result register when popped.
// The back end takes one byte per cycle except while such a stalled result holds it back.
// A four-entry queue lets the input keep flowing while a result waits to be taken.
// Reset is synchronous and active high; it empties the queue and closes any open frame.
module escaped_frame_receive_deframer_core import efd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  logic [2:0]  frame_length,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  error_code,
  output logic [7:0]  device_status,
  output logic [31:0] data_value,
  output logic        bad_escape
);

  rx_item_t front_item;
  rx_item_t queue_item;
  logic     queue_full;
  logic     queue_valid;
  logic     queue_pop;
  result_t  result;

  efd_front u_front (
    .rx_byte      (rx_byte),
    .frame_start  (frame_start),
    .frame_length (frame_length),
    .item         (front_item)
  );

  efd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (rx_valid),
    .push_item  (front_item),
    .full       (queue_full),
    .pop        (queue_pop),
    .pop_valid  (queue_valid),
    .pop_item   (queue_item)
  );

  efd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (queue_valid),
    .item         (queue_item),
    .pop          (queue_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign rx_stall      = queue_full;
  assign error_code    = result.error_code;
  assign device_status = result.device_status;
  assign data_value    = result.data_value;
  assign bad_escape    = result.bad_escape;

endmodule

>>> rtl/core/efd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
module efd_checker import efd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  error_code,
  input logic [7:0]  device_status,
  input logic [31:0] data_value,
  input logic        bad_escape
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(error_code) &&
      $stable(device_status) && $stable(data_value) && $stable(bad_escape))
    else $error("Stalled result request changed.");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (error_code == ERR_OK) || (error_code == ERR_CHECKSUM) ||
      (error_code == ERR_STATUS))
    else $error("Result carries an undefined error code.");

  a_status_err: assert property (@(posedge clk) disable iff (rst)
    result_valid && (error_code == ERR_STATUS) |-> device_status != 8'h00)
    else $error("Status error reported with a zero status byte.");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && (error_code == ERR_OK) |-> device_status == 8'h00)
    else $error("Good frame reported with a nonzero status byte.");

endmodule

bind escaped_frame_receive_deframer_core efd_checker u_efd_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .error_code    (error_code),
  .device_status (device_status),
  .data_value    (data_value),
  .bad_escape    (bad_escape)
);
